// File: rtl/core/sha1_mh_pkg.sv
// Shared types and constants for the SHA-1 message hash block.
// Used by the front end, the command queue, the engine and the top level.
package sha1_mh_pkg;

   localparam int QueueDepth    = 4;
   localparam int QueueAddrBits = $clog2(QueueDepth);

   localparam logic [2:0] LastWordIndex = 3'd4;
   localparam logic [7:0] PadMarker     = 8'h80;

   localparam logic [31:0] RoundConst0 = 32'h5A827999;
   localparam logic [31:0] RoundConst1 = 32'h6ED9EBA1;
   localparam logic [31:0] RoundConst2 = 32'h8F1BBCDC;
   localparam logic [31:0] RoundConst3 = 32'hCA62C1D6;

   localparam logic [4:0][31:0] InitVector = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   typedef struct packed {
      logic       has_byte;
      logic       eom;
      logic [7:0] data;
   } cmd_type;

endpackage

// File: rtl/core/sha1_mh_front.sv
// Front end of the SHA-1 message hash block: accepts input transfers and
// classifies them into queue commands. Depends on sha1_mh_pkg.
module sha1_mh_front
   import sha1_mh_pkg::*;
(
   input  logic       req_push,
   input  logic [7:0] req_data_byte,
   input  logic       req_byte_valid,
   input  logic       req_end_of_message,
   output logic       req_full,
   input  logic       q_full,
   output logic       q_push,
   output cmd_type    q_cmd
);

   // Transfers that carry neither a byte nor an end mark are taken and dropped.
   assign req_full       = q_full;
   assign q_push         = req_push & ~q_full & (req_byte_valid | req_end_of_message);
   assign q_cmd.has_byte = req_byte_valid;
   assign q_cmd.eom      = req_end_of_message;
   assign q_cmd.data     = req_data_byte;

endmodule

// File: rtl/core/sha1_mh_queue.sv
// Short command queue between the front end and the engine.
// Depends on sha1_mh_pkg for the command type and the depth.
module sha1_mh_queue
   import sha1_mh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    full,
   output logic    empty
);

   cmd_type                  mem_ff [QueueDepth];
   logic [QueueAddrBits-1:0] wr_ptr_ff;
   logic [QueueAddrBits-1:0] rd_ptr_ff;
   logic [QueueAddrBits:0]   count_ff;
   logic                     do_push;
   logic                     do_pop;

   assign full     = (count_ff == QueueDepth[QueueAddrBits:0]);
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign head_cmd = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// File: rtl/core/sha1_mh_engine.sv
// Back end of the SHA-1 message hash block: block buffer, padding, the
// 80-round compression and the digest output register. Depends on sha1_mh_pkg.
module sha1_mh_engine
   import sha1_mh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  cmd_type     q_cmd,
   output logic        q_pop,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PAD,
      S_ROUND,
      S_UPDATE,
      S_FINAL
   } state_type;

   typedef enum logic [1:0] {
      PH_MARK,
      PH_ZERO,
      PH_LEN
   } phase_type;

   state_type        state_ff;
   phase_type        phase_ff;
   logic [511:0]     blk_ff;
   logic [5:0]       fill_ff;
   logic [63:0]      count_ff;
   logic [63:0]      len_ff;
   logic             in_pad_ff;
   logic             final_ff;
   logic [6:0]       round_ff;
   logic [31:0]      a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [4:0][31:0] h_ff;
   logic             out_valid_ff;
   logic [2:0]       out_idx_ff;
   logic [4:0][31:0] out_words_ff;

   logic [31:0] f_in;
   logic [31:0] k_in;
   logic [31:0] tmp_in;
   logic [31:0] mix_in;
   logic [31:0] sched_in;
   logic [63:0] count_in;
   logic        len_byte_in;
   logic [7:0]  pad_byte_in;

   always_comb begin
      if (round_ff < 7'd20) begin
         f_in = (b_ff & c_ff) | (~b_ff & d_ff);
         k_in = RoundConst0;
      end else if (round_ff < 7'd40) begin
         f_in = b_ff ^ c_ff ^ d_ff;
         k_in = RoundConst1;
      end else if (round_ff < 7'd60) begin
         f_in = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_in = RoundConst2;
      end else begin
         f_in = b_ff ^ c_ff ^ d_ff;
         k_in = RoundConst3;
      end
      tmp_in   = {a_ff[26:0], a_ff[31:27]} + f_in + e_ff + blk_ff[511:480] + k_in;
      mix_in   = blk_ff[511:480] ^ blk_ff[447:416] ^ blk_ff[255:224] ^ blk_ff[95:64];
      sched_in = {mix_in[30:0], mix_in[31]};
      count_in = q_cmd.has_byte ? count_ff + 64'd8 : count_ff;
      len_byte_in = (phase_ff == PH_LEN) || (phase_ff == PH_ZERO && fill_ff == 6'd56);
      if (phase_ff == PH_MARK) begin
         pad_byte_in = PadMarker;
      end else if (len_byte_in) begin
         pad_byte_in = len_ff[63:56];
      end else begin
         pad_byte_in = 8'h00;
      end
   end

   assign q_pop           = (state_ff == S_IDLE) & ~q_empty;
   assign rsp_empty       = ~out_valid_ff;
   assign rsp_digest_word = out_words_ff[0];
   assign rsp_word_index  = out_idx_ff;
   assign rsp_last_word   = (out_idx_ff == LastWordIndex);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_MARK;
         fill_ff      <= '0;
         count_ff     <= '0;
         in_pad_ff    <= 1'b0;
         final_ff     <= 1'b0;
         round_ff     <= '0;
         h_ff         <= InitVector;
         out_valid_ff <= 1'b0;
         out_idx_ff   <= '0;
      end else begin
         if (rsp_pop && out_valid_ff) begin
            if (out_idx_ff == LastWordIndex) begin
               out_valid_ff <= 1'b0;
            end else begin
               out_idx_ff   <= out_idx_ff + 3'd1;
               out_words_ff <= {32'h0, out_words_ff[4:1]};
            end
         end
         unique case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  count_ff  <= count_in;
                  len_ff    <= count_in;
                  phase_ff  <= PH_MARK;
                  in_pad_ff <= q_cmd.eom;
                  final_ff  <= 1'b0;
                  if (q_cmd.has_byte) begin
                     blk_ff  <= {blk_ff[503:0], q_cmd.data};
                     fill_ff <= fill_ff + 6'd1;
                  end
                  if (q_cmd.has_byte && fill_ff == 6'd63) begin
                     state_ff <= S_ROUND;
                     round_ff <= '0;
                     {a_ff, b_ff, c_ff, d_ff, e_ff} <= {h_ff[0], h_ff[1], h_ff[2],
                                                        h_ff[3], h_ff[4]};
                  end else if (q_cmd.eom) begin
                     state_ff <= S_PAD;
                  end
               end
            end
            S_PAD: begin
               blk_ff  <= {blk_ff[503:0], pad_byte_in};
               fill_ff <= fill_ff + 6'd1;
               if (phase_ff == PH_MARK) begin
                  phase_ff <= PH_ZERO;
               end else if (len_byte_in) begin
                  phase_ff <= PH_LEN;
                  len_ff   <= {len_ff[55:0], 8'h00};
               end
               if (fill_ff == 6'd63) begin
                  state_ff <= S_ROUND;
                  round_ff <= '0;
                  final_ff <= len_byte_in;
                  {a_ff, b_ff, c_ff, d_ff, e_ff} <= {h_ff[0], h_ff[1], h_ff[2],
                                                     h_ff[3], h_ff[4]};
               end
            end
            S_ROUND: begin
               a_ff     <= tmp_in;
               b_ff     <= a_ff;
               c_ff     <= {b_ff[1:0], b_ff[31:2]};
               d_ff     <= c_ff;
               e_ff     <= d_ff;
               blk_ff   <= {blk_ff[479:0], sched_in};
               round_ff <= round_ff + 7'd1;
               if (round_ff == 7'd79) begin
                  state_ff <= S_UPDATE;
               end
            end
            S_UPDATE: begin
               h_ff[0] <= h_ff[0] + a_ff;
               h_ff[1] <= h_ff[1] + b_ff;
               h_ff[2] <= h_ff[2] + c_ff;
               h_ff[3] <= h_ff[3] + d_ff;
               h_ff[4] <= h_ff[4] + e_ff;
               if (final_ff) begin
                  state_ff <= S_FINAL;
               end else if (in_pad_ff) begin
                  state_ff <= S_PAD;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_FINAL: begin
               if (!out_valid_ff) begin
                  out_words_ff <= h_ff;
                  out_idx_ff   <= '0;
                  out_valid_ff <= 1'b1;
                  h_ff         <= InitVector;
                  count_ff     <= '0;
                  fill_ff      <= '0;
                  in_pad_ff    <= 1'b0;
                  final_ff     <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// File: rtl/core/sha1_message_hash.sv
// Top level of the SHA-1 message hash block: front end, command queue and
// engine. Depends on sha1_mh_pkg, sha1_mh_front, sha1_mh_queue, sha1_mh_engine.
//
// Input transfers take place when req_push is high and req_full is low. Each
// carries an optional message byte (req_byte_valid) and an optional end mark.
// Transfers with neither are taken and have no effect. A four-entry queue sits
// in front of the engine, so input is taken while the engine compresses.
// The engine absorbs one byte per cycle while idle; every 64th byte starts a
// compression (80 rounds on one shared round unit, then one chaining update)
// during which no bytes are taken. An end mark adds padding and one or two
// compressions, after which the engine loads the five digest words.
// Results are read like a queue: while rsp_empty is low, word rsp_word_index
// of the digest is shown, and rsp_pop takes it; rsp_last_word marks word four.
// If the receiver stalls, the engine holds a finished digest until the
// previous one has been fully taken, and the queue then fills and raises
// req_full. Synchronous reset empties both queues and restores the initial
// chaining value; no clearing pass is needed.
module sha1_message_hash
   import sha1_mh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_message,
   output logic        req_full,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   cmd_type push_cmd;
   cmd_type head_cmd;
   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;

   sha1_mh_front u_front (
      .req_push           (req_push),
      .req_data_byte      (req_data_byte),
      .req_byte_valid     (req_byte_valid),
      .req_end_of_message (req_end_of_message),
      .req_full           (req_full),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_cmd              (push_cmd)
   );

   sha1_mh_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   sha1_mh_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_cmd           (head_cmd),
      .q_pop           (q_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   // The last flag and the word index must agree.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_last_word |-> rsp_word_index == LastWordIndex)
      else $error("last word flag without final word index");

   // Taking a word that is not the last must present the next word at once.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_pop && !rsp_last_word |=>
         !rsp_empty && rsp_word_index == $past(rsp_word_index) + 3'd1)
      else $error("digest words not delivered in order");

   // Reset leaves no result waiting.
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending after reset");

endmodule

// File: tb/sha1_digest_check_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the SHA-1 message hash testbench: a streaming SHA-1 digest
// predictor and the queue of digest words it expects. Depends on nothing else.
package sha1_digest_check_pkg;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   class sha1_digest_tracker;
      logic [31:0]     chain [5];
      logic [7:0]      block_buf [64];
      logic [63:0]     bit_count;
      int unsigned     fill;
      digest_word_type pending [$];
      int unsigned     mismatches;
      int unsigned     words_checked;

      function new();
         foreach (block_buf[i]) block_buf[i] = 8'h00;
         mismatches    = 0;
         words_checked = 0;
         restart();
      endfunction

      function void restart();
         chain[0]  = 32'h67452301;
         chain[1]  = 32'hEFCDAB89;
         chain[2]  = 32'h98BADCFE;
         chain[3]  = 32'h10325476;
         chain[4]  = 32'hC3D2E1F0;
         bit_count = 64'd0;
         fill      = 0;
      endfunction

      function logic [31:0] rotl(logic [31:0] x, int unsigned n);
         return (x << n) | (x >> (32 - n));
      endfunction

      function void compress();
         logic [31:0] w [80];
         logic [31:0] a, b, c, d, e, f, k, t;
         for (int r = 0; r < 16; r++) begin
            w[r] = {block_buf[4*r], block_buf[4*r+1], block_buf[4*r+2], block_buf[4*r+3]};
         end
         for (int r = 16; r < 80; r++) begin
            w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
         end
         a = chain[0];
         b = chain[1];
         c = chain[2];
         d = chain[3];
         e = chain[4];
         for (int r = 0; r < 80; r++) begin
            if (r < 20) begin
               f = (b & c) | (~b & d);
               k = 32'h5A827999;
            end else if (r < 40) begin
               f = b ^ c ^ d;
               k = 32'h6ED9EBA1;
            end else if (r < 60) begin
               f = (b & c) | (b & d) | (c & d);
               k = 32'h8F1BBCDC;
            end else begin
               f = b ^ c ^ d;
               k = 32'hCA62C1D6;
            end
            t = rotl(a, 5) + f + e + w[r] + k;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
         end
         chain[0] += a;
         chain[1] += b;
         chain[2] += c;
         chain[3] += d;
         chain[4] += e;
      endfunction

      // Called for every accepted input transfer.
      function void note_item(logic [7:0] data, logic has_byte, logic eom);
         int unsigned     pos;
         digest_word_type dw;
         if (has_byte) begin
            block_buf[fill] = data;
            bit_count += 64'd8;
            fill++;
            if (fill == 64) begin
               compress();
               fill = 0;
            end
         end
         if (!eom) return;
         pos = fill;
         block_buf[pos] = 8'h80;
         pos++;
         if (pos > 56) begin
            while (pos < 64) begin
               block_buf[pos] = 8'h00;
               pos++;
            end
            compress();
            pos = 0;
         end
         while (pos < 56) begin
            block_buf[pos] = 8'h00;
            pos++;
         end
         for (int i = 0; i < 8; i++) begin
            block_buf[56+i] = 8'(bit_count >> (56 - 8*i));
         end
         compress();
         for (int i = 0; i < 5; i++) begin
            dw.word  = chain[i];
            dw.index = 3'(i);
            dw.last  = (i == 4);
            pending.push_back(dw);
         end
         restart();
      endfunction

      // Called for every accepted result transfer.
      function void check_word(logic [31:0] word, logic [2:0] index, logic last);
         digest_word_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected digest word %h at index %0d", $time, word, index);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         words_checked++;
         if (word !== want.word) begin
            $display("%0t: rsp_digest_word expected %h, got %h", $time, want.word, word);
            mismatches++;
         end
         if (index !== want.index) begin
            $display("%0t: rsp_word_index expected %0d, got %0d", $time, want.index, index);
            mismatches++;
         end
         if (last !== want.last) begin
            $display("%0t: rsp_last_word expected %b, got %b", $time, want.last, last);
            mismatches++;
         end
      endfunction
   endclass

endpackage

// File: tb/tb.sv
`timescale 1ns / 100ps
// Top level of the SHA-1 message hash testbench: clock, reset, stimulus and
// the result reader. Depends on sha1_digest_check_pkg and sha1_message_hash.
module tb;
   import sha1_digest_check_pkg::*;

   localparam int RandomItemTarget = 375;
   localparam int WatchdogLimit    = 3000;
   localparam int DrainCycles      = 300;

   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        req_push           = 1'b0;
   logic [7:0]  req_data_byte      = 8'h00;
   logic        req_byte_valid     = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_pop            = 1'b0;
   logic        req_full;
   logic        rsp_empty;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   sha1_digest_tracker digests = new();

   int unsigned idle_cycles    = 0;
   int unsigned messages_sent  = 0;
   int unsigned bytes_sent     = 0;
   int unsigned random_items   = 0;
   int unsigned receiver_stall = 0;
   bit          quiet_sender   = 1'b0;
   bit          quiet_receiver = 1'b0;
   bit          paused_midway  = 1'b0;

   sha1_message_hash dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_data_byte      (req_data_byte),
      .req_byte_valid     (req_byte_valid),
      .req_end_of_message (req_end_of_message),
      .req_full           (req_full),
      .rsp_pop            (rsp_pop),
      .rsp_empty          (rsp_empty),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WatchdogLimit) begin
         $display("%0t: no transfer for %0d cycles", $time, WatchdogLimit);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet_sender || roll < 60) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   function automatic int pick_stall();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 96) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_item(input logic [7:0] data, input logic has_byte, input logic eom);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push           <= 1'b1;
      req_data_byte      <= data;
      req_byte_valid     <= has_byte;
      req_end_of_message <= eom;
      do @(posedge clock); while (req_full);
      digests.note_item(data, has_byte, eom);
      if (has_byte) bytes_sent++;
      if (eom) messages_sent++;
   endtask

   task automatic hold_until_drained();
      req_push <= 1'b0;
      do @(posedge clock); while (digests.pending.size() != 0);
   endtask

   // Idle transfers with neither a byte nor an end mark are sprinkled in.
   task automatic send_message(input int len, input bit end_with_byte);
      logic eom;
      quiet_sender = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
         eom = end_with_byte && (i == len - 1);
         send_item(8'($urandom), 1'b1, eom);
         random_items++;
      end
      if (!end_with_byte || len == 0) begin
         send_item(8'($urandom), 1'b0, 1'b1);
         random_items++;
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            digests.check_word(rsp_digest_word, rsp_word_index, rsp_last_word);
         end
         if ($urandom_range(0, 299) == 0) quiet_receiver = !quiet_receiver;
         if (receiver_stall > 0) begin
            rsp_pop <= 1'b0;
            receiver_stall--;
         end else begin
            rsp_pop <= 1'b1;
            if (!quiet_receiver) receiver_stall = pick_stall();
         end
      end
   end

   initial begin
      int len;
      int roll;
      int boundary [9];
      boundary = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Empty message, an idle transfer, and one-byte messages at the byte extremes.
      send_item(8'hFF, 1'b0, 1'b1);
      send_item(8'hFF, 1'b0, 1'b0);
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hFF, 1'b1, 1'b1);
      // "abc" with the end mark on the last byte, then with a separate end mark.
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'hA5, 1'b0, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b0);
      send_item(8'h5A, 1'b0, 1'b1);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h80, 1'b1, 1'b1);
      hold_until_drained();

      while (random_items < RandomItemTarget) begin
         roll = $urandom_range(0, 99);
         if (roll < 55) len = $urandom_range(0, 8);
         else if (roll < 85) len = $urandom_range(9, 54);
         else len = boundary[$urandom_range(0, 8)];
         send_message(len, $urandom_range(0, 1));
         if (!paused_midway && random_items >= RandomItemTarget / 2) begin
            paused_midway = 1'b1;
            hold_until_drained();
         end
      end

      hold_until_drained();
      repeat (DrainCycles) @(posedge clock);
      if (digests.pending.size() != 0) begin
         $display("%0t: %0d digest words never arrived", $time, digests.pending.size());
         digests.mismatches++;
      end
      $display("Hashed %0d messages of %0d bytes in total; %0d digest words compared.",
               messages_sent, bytes_sent, digests.words_checked);
      $display("Mismatches found: %0d.", digests.mismatches);
      if (digests.mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
